/* src/dvcs_pkg.sv */
// Package for the distance-to-volume command sender: register indexes, frame bytes,
// microcode operations and the control store of the sequencer.
// No dependencies; imported by distance_to_volume_command_sender.
package dvcs_pkg;

   localparam int FRAME_BYTES = 7;

   localparam logic [2:0] CSR_NEAR_LIMIT     = 3'd0;
   localparam logic [2:0] CSR_FAR_LIMIT      = 3'd1;
   localparam logic [2:0] CSR_VOLUME_FLOOR   = 3'd2;
   localparam logic [2:0] CSR_VOLUME_CEILING = 3'd3;
   localparam logic [2:0] CSR_START_HOLDOFF  = 3'd4;
   localparam logic [2:0] CSR_SEND_INTERVAL  = 3'd5;

   localparam logic [15:0] NEAR_LIMIT_RST     = 16'd100;
   localparam logic [15:0] FAR_LIMIT_RST      = 16'd1000;
   localparam logic [7:0]  VOLUME_FLOOR_RST   = 8'd0;
   localparam logic [7:0]  VOLUME_CEILING_RST = 8'd30;
   localparam logic [15:0] START_HOLDOFF_RST  = 16'd500;
   localparam logic [15:0] SEND_INTERVAL_RST  = 16'd200;

   localparam logic [7:0] BYTE_HEAD      = 8'hFE;
   localparam logic [7:0] BYTE_LEN_PLAY  = 8'h07;
   localparam logic [7:0] BYTE_LEN_VOL   = 8'h08;
   localparam logic [7:0] BYTE_ADDR      = 8'hFF;
   localparam logic [7:0] BYTE_CMD_PLAY  = 8'h02;
   localparam logic [7:0] BYTE_ARG_PLAY  = 8'h05;
   localparam logic [7:0] BYTE_CMD_VOL   = 8'h13;
   localparam logic [7:0] BYTE_TAIL      = 8'hBE;

   typedef logic [4:0] step_type;

   localparam step_type STEP_IDLE  = 5'd0;
   localparam step_type STEP_CHECK = 5'd10;
   localparam step_type STEP_DIV   = 5'd15;
   localparam step_type STEP_SEND  = 5'd17;

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_TICK,
      OP_START,
      OP_EMIT,
      OP_HOLD,
      OP_GAP,
      OP_CLASS,
      OP_MUL,
      OP_DIVINIT,
      OP_DIVSTEP,
      OP_DIVFIN,
      OP_JUMP
   } op_type;

   typedef struct packed {
      op_type     op;
      step_type   jmp;
      logic [7:0] tx_const;
      logic       use_vol;
      logic       last;
   } ctrl_word_type;

   function automatic ctrl_word_type ctl(op_type op, step_type jmp, logic [7:0] tx_const,
                                         logic use_vol, logic last);
      ctrl_word_type w;
      w.op       = op;
      w.jmp      = jmp;
      w.tx_const = tx_const;
      w.use_vol  = use_vol;
      w.last     = last;
      return w;
   endfunction

   function automatic ctrl_word_type dvcs_rom(step_type s);
      ctrl_word_type w;
      case (s)
         5'd0:  w = ctl(OP_WAIT,    STEP_IDLE,  8'h00,         1'b0, 1'b0);
         5'd1:  w = ctl(OP_TICK,    STEP_IDLE,  8'h00,         1'b0, 1'b0);
         5'd2:  w = ctl(OP_START,   STEP_CHECK, 8'h00,         1'b0, 1'b0);
         5'd3:  w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_HEAD,     1'b0, 1'b0);
         5'd4:  w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_LEN_PLAY, 1'b0, 1'b0);
         5'd5:  w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_ADDR,     1'b0, 1'b0);
         5'd6:  w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_ADDR,     1'b0, 1'b0);
         5'd7:  w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_CMD_PLAY, 1'b0, 1'b0);
         5'd8:  w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_ARG_PLAY, 1'b0, 1'b0);
         5'd9:  w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_TAIL,     1'b0, 1'b1);
         5'd10: w = ctl(OP_HOLD,    STEP_IDLE,  8'h00,         1'b0, 1'b0);
         5'd11: w = ctl(OP_GAP,     STEP_IDLE,  8'h00,         1'b0, 1'b0);
         5'd12: w = ctl(OP_CLASS,   STEP_SEND,  8'h00,         1'b0, 1'b0);
         5'd13: w = ctl(OP_MUL,     STEP_IDLE,  8'h00,         1'b0, 1'b0);
         5'd14: w = ctl(OP_DIVINIT, STEP_IDLE,  8'h00,         1'b0, 1'b0);
         5'd15: w = ctl(OP_DIVSTEP, STEP_DIV,   8'h00,         1'b0, 1'b0);
         5'd16: w = ctl(OP_DIVFIN,  STEP_IDLE,  8'h00,         1'b0, 1'b0);
         5'd17: w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_HEAD,     1'b0, 1'b0);
         5'd18: w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_LEN_VOL,  1'b0, 1'b0);
         5'd19: w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_ADDR,     1'b0, 1'b0);
         5'd20: w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_ADDR,     1'b0, 1'b0);
         5'd21: w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_CMD_VOL,  1'b0, 1'b0);
         5'd22: w = ctl(OP_EMIT,    STEP_IDLE,  8'h00,         1'b1, 1'b0);
         5'd23: w = ctl(OP_EMIT,    STEP_IDLE,  BYTE_TAIL,     1'b0, 1'b1);
         default: w = ctl(OP_JUMP,  STEP_IDLE,  8'h00,         1'b0, 1'b0);
      endcase
      return w;
   endfunction

endpackage

/* src/distance_to_volume_command_sender.sv */
// Distance-to-volume command sender: microcoded sequencer with time stamps, volume
// classifier, 16x8 multiplier and a one-bit-per-step divider.
// Depends on dvcs_pkg (control store, constants, types).
//
// Usage:
//   req channel: one transaction is a millisecond tick (req_tuser = 0) or a distance
//   sample (req_tuser = 1, distance in req_tdata). rsp channel: command frame bytes,
//   seven per frame, rsp_tlast on the seventh. csr port: single-cycle register writes;
//   write only while no request is in flight.
//   The sequencer takes one request at a time; req_tready is high only in the idle step.
//   Paths through the control store per request:
//     tick: the wait and tick steps, then back to idle
//     dropped sample: stops at the holdoff or the send-interval check
//     play frame: one byte per cycle after three control steps, unless rsp stalls
//     volume frame at floor or ceiling: the classifier, then the seven byte steps
//     volume frame in the middle band: multiply, divide set-up, the 8-step divide loop
//   and the seven byte steps.
//   rsp stall: the sequencer holds on the current byte step until the output register
//   frees; the last byte may still wait in the output register while the next request
//   is accepted.
//   Reset: registers return to their defaults, time stamps and the play flag clear,
//   and the output register empties. No clearing pass.
module distance_to_volume_command_sender
   import dvcs_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] distance
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] tx_byte
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] near_ff, far_ff, holdoff_ff, interval_ff;
   logic [7:0]  floor_ff, ceiling_ff;

   step_type step_ff, step_in;
   logic     playing_ff, playing_in;
   logic [TIME_BITS-1:0] now_ff, now_in, start_ff, start_in, last_ff, last_in;

   logic        opcode_ff, opcode_in;
   logic [15:0] dist_ff, dist_in;
   logic [7:0]  vol_ff, vol_in;
   logic [23:0] prod_ff, prod_in;
   logic [15:0] den_ff, den_in;
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  quo_ff, quo_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   ctrl_word_type cw;
   logic          stall, cond, load, far_or_zero;
   logic [16:0]   trial;
   logic [7:0]    span;
   logic [15:0]   offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff     <= NEAR_LIMIT_RST;
         far_ff      <= FAR_LIMIT_RST;
         floor_ff    <= VOLUME_FLOOR_RST;
         ceiling_ff  <= VOLUME_CEILING_RST;
         holdoff_ff  <= START_HOLDOFF_RST;
         interval_ff <= SEND_INTERVAL_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NEAR_LIMIT:     near_ff     <= csr_wdata;
            CSR_FAR_LIMIT:      far_ff      <= csr_wdata;
            CSR_VOLUME_FLOOR:   floor_ff    <= csr_wdata[7:0];
            CSR_VOLUME_CEILING: ceiling_ff  <= csr_wdata[7:0];
            CSR_START_HOLDOFF:  holdoff_ff  <= csr_wdata;
            CSR_SEND_INTERVAL:  interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         playing_ff   <= 1'b0;
         now_ff       <= '0;
         start_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         playing_ff   <= playing_in;
         now_ff       <= now_in;
         start_ff     <= start_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff   <= opcode_in;
      dist_ff     <= dist_in;
      vol_ff      <= vol_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      cw           = dvcs_rom(step_ff);
      stall        = 1'b0;
      cond         = 1'b0;
      load         = 1'b0;
      req_tready   = 1'b0;
      playing_in   = playing_ff;
      now_in       = now_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      opcode_in    = opcode_ff;
      dist_in      = dist_ff;
      vol_in       = vol_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      far_or_zero  = (dist_ff == 16'd0) || (dist_ff >= far_ff);
      span         = (floor_ff > ceiling_ff) ? 8'd0 : 8'(ceiling_ff - floor_ff);
      offset       = 16'(dist_ff - near_ff);
      trial        = {rem_ff, low_ff[7]};

      case (cw.op)
         OP_WAIT: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               opcode_in = req_tuser;
               dist_in   = req_tdata;
            end else begin
               stall = 1'b1;
            end
         end
         OP_TICK: begin
            cond = !opcode_ff;
            if (cond) begin
               now_in = TIME_BITS'(now_ff + 1'b1);
            end
         end
         OP_START: begin
            cond = playing_ff;
            if (!playing_ff) begin
               playing_in = 1'b1;
               start_in   = now_ff;
            end
         end
         OP_EMIT: begin
            load  = !rsp_valid_ff || rsp_tready;
            stall = !load;
            cond  = cw.last;
         end
         OP_HOLD: begin
            cond = TIME_BITS'(now_ff - start_ff) < TIME_BITS'(holdoff_ff);
         end
         OP_GAP: begin
            cond = TIME_BITS'(now_ff - last_ff) < TIME_BITS'(interval_ff);
            if (!cond) begin
               last_in = now_ff;
            end
         end
         OP_CLASS: begin
            cond   = far_or_zero || (dist_ff < near_ff);
            vol_in = far_or_zero ? floor_ff : ceiling_ff;
         end
         OP_MUL: begin
            prod_in = 24'(offset) * 24'(span);
            den_in  = 16'(far_ff - near_ff);
         end
         OP_DIVINIT: begin
            rem_in = prod_ff[23:8];
            low_in = prod_ff[7:0];
            quo_in = 8'd0;
            cnt_in = 3'd7;
         end
         OP_DIVSTEP: begin
            cond   = (cnt_ff != 3'd0);
            cnt_in = 3'(cnt_ff - 1'b1);
            low_in = {low_ff[6:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 16'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[6:0], 1'b1};
            end else begin
               rem_in = trial[15:0];
               quo_in = {quo_ff[6:0], 1'b0};
            end
         end
         OP_DIVFIN: begin
            vol_in = 8'(ceiling_ff - quo_ff - {7'd0, rem_ff != 16'd0});
         end
         OP_JUMP: begin
            cond = 1'b1;
         end
         default: begin
            cond = 1'b1;
         end
      endcase

      if (stall) begin
         step_in = step_ff;
      end else if (cond) begin
         step_in = cw.jmp;
      end else begin
         step_in = 5'(step_ff + 1'b1);
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cw.use_vol ? vol_ff : cw.tx_const;
         rsp_last_in  = cw.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* src/dvcs_checker.sv */
// Port-level checks for the distance-to-volume command sender, and the bind that
// attaches them to the top level. Depends on distance_to_volume_command_sender ports.
module dvcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted twice in a row");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_frame_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |-> rsp_tdata == 8'hBE)
      else $error("frame does not end with tail byte");

endmodule

bind distance_to_volume_command_sender dvcs_checker u_dvcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* dv/tb_top.sv */
// Testbench for distance_to_volume_command_sender: directed and random tick and sample
// transactions, a predictor of the command frames and a byte-by-byte scoreboard.
// Depends on dvcs_pkg and the RTL of the block.
module tb_top
   import dvcs_pkg::*;
;

   localparam int HALF_PERIOD    = 4;
   localparam int SETTLE_CYCLES  = 32;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [2:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [2:0] CSR_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
   } frame_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] distance
   logic        req_tuser  = 1'b0; // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] tx_byte
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   logic [15:0] near_mm, far_mm, holdoff_ms, interval_ms;
   logic [7:0]  vol_floor, vol_ceiling;
   logic [31:0] now_ms, start_ms, last_send_ms;
   logic        playing;

   frame_byte_type pending_bytes[$];
   int          mismatches    = 0;
   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   int          quiet_cycles  = 0;

   distance_to_volume_command_sender dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [7:0] volume_for(input logic [15:0] d);
      logic [31:0] span, num, den;
      if (d == 16'd0 || d >= far_mm) return vol_floor;
      if (d < near_mm) return vol_ceiling;
      span = (vol_floor > vol_ceiling) ? 32'd0 : 32'(vol_ceiling - vol_floor);
      num  = 32'(d - near_mm) * span;
      den  = 32'(far_mm - near_mm);
      return vol_ceiling - 8'((num + den - 32'd1) / den);
   endfunction

   function automatic void push_frame(input logic [7:0] len_b, cmd_b, arg_b);
      logic [7:0] fb [FRAME_BYTES];
      fb = '{BYTE_HEAD, len_b, BYTE_ADDR, BYTE_ADDR, cmd_b, arg_b, BYTE_TAIL};
      for (int k = 0; k < FRAME_BYTES; k++)
         pending_bytes.push_back('{fb[k], (k == FRAME_BYTES - 1)});
   endfunction

   function automatic void predict_command(input logic op, input logic [15:0] d);
      if (op == CMD_TICK) begin
         now_ms = now_ms + 32'd1;
         return;
      end
      if (!playing) begin
         playing  = 1'b1;
         start_ms = now_ms;
         push_frame(BYTE_LEN_PLAY, BYTE_CMD_PLAY, BYTE_ARG_PLAY);
         return;
      end
      if (now_ms - start_ms < 32'(holdoff_ms)) return;
      if (now_ms - last_send_ms < 32'(interval_ms)) return;
      last_send_ms = now_ms;
      push_frame(BYTE_LEN_VOL, BYTE_CMD_VOL, volume_for(d));
   endfunction

   function automatic void report_mismatch(input string what);
      if (mismatches < 50) $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endfunction

   always @(posedge clock) begin : check_rsp
      frame_byte_type want;
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.tx_byte)
               report_mismatch($sformatf("tx_byte %02h, want %02h", rsp_tdata, want.tx_byte));
            if (rsp_tlast !== want.frame_end)
               report_mismatch($sformatf("frame_end %0b, want %0b", rsp_tlast, want.frame_end));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction in %0d cycles", WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_item(input logic op, input logic [15:0] d);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      predict_command(op, d);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_NEAR_LIMIT:     near_mm     = val;
         CSR_FAR_LIMIT:      far_mm      = val;
         CSR_VOLUME_FLOOR:   vol_floor   = val[7:0];
         CSR_VOLUME_CEILING: vol_ceiling = val[7:0];
         CSR_START_HOLDOFF:  holdoff_ms  = val;
         CSR_SEND_INTERVAL:  interval_ms = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] near_v, far_v, input logic [7:0] flo_v, ceil_v,
                             input logic [15:0] hold_v, intv_v);
      settle();
      write_reg(CSR_NEAR_LIMIT, near_v);
      write_reg(CSR_FAR_LIMIT, far_v);
      write_reg(CSR_VOLUME_FLOOR, {8'($urandom), flo_v});
      write_reg(CSR_VOLUME_CEILING, {8'($urandom), ceil_v});
      write_reg(CSR_START_HOLDOFF, hold_v);
      write_reg(CSR_SEND_INTERVAL, intv_v);
      csr_we <= 1'b0;
   endtask

   task automatic test_play_frame();
      send_item(CMD_TICK, 16'h0000);
      send_item(CMD_TICK, 16'hFFFF);
      send_item(CMD_SAMPLE, 16'hFFFF);
      send_item(CMD_SAMPLE, 16'd500);
   endtask

   task automatic test_volume_bands();
      set_config(16'd100, 16'd1000, 8'd0, 8'd30, 16'd0, 16'd0);
      @(posedge clock);
      write_reg(CSR_UNUSED_LO, 16'($urandom));
      write_reg(CSR_UNUSED_HI, 16'($urandom));
      csr_we <= 1'b0;
      send_item(CMD_SAMPLE, 16'd0);
      send_item(CMD_SAMPLE, 16'd99);
      send_item(CMD_SAMPLE, 16'd100);
      send_item(CMD_SAMPLE, 16'd550);
      send_item(CMD_SAMPLE, 16'd999);
      send_item(CMD_SAMPLE, 16'd1000);
      send_item(CMD_SAMPLE, 16'hFFFF);
   endtask

   task automatic test_floor_above_ceiling();
      set_config(16'd100, 16'd1000, 8'd200, 8'd10, 16'd0, 16'd0);
      send_item(CMD_SAMPLE, 16'd500);
      send_item(CMD_SAMPLE, 16'd0);
   endtask

   task automatic test_empty_middle_band();
      set_config(16'd1000, 16'd100, 8'd7, 8'd50, 16'd0, 16'd0);
      send_item(CMD_SAMPLE, 16'd500);
      send_item(CMD_SAMPLE, 16'd50);
      set_config(16'd0, 16'd1000, 8'd7, 8'd50, 16'd0, 16'd0);
      send_item(CMD_SAMPLE, 16'd0);
   endtask

   task automatic test_full_scale();
      set_config(16'd0, 16'hFFFF, 8'd0, 8'hFF, 16'd0, 16'd0);
      send_item(CMD_SAMPLE, 16'd1);
      send_item(CMD_SAMPLE, 16'hFFFE);
   endtask

   task automatic test_send_interval();
      set_config(16'd100, 16'd1000, 8'd0, 8'd30, 16'hFFFF, 16'd0);
      send_item(CMD_SAMPLE, 16'd300);
      set_config(16'd100, 16'd1000, 8'd0, 8'd30, 16'd0, 16'hFFFF);
      send_item(CMD_SAMPLE, 16'd300);
      set_config(16'd100, 16'd1000, 8'd0, 8'd30, 16'd0, 16'd3);
      send_item(CMD_SAMPLE, 16'd300);
      repeat (3) send_item(CMD_TICK, 16'($urandom));
      send_item(CMD_SAMPLE, 16'd300);
      send_item(CMD_SAMPLE, 16'd700);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
      logic [15:0] near_r, far_r, d;
      logic        op;
      near_r = 16'($urandom_range(0, 3000));
      far_r  = near_r + 16'($urandom_range(1, 4000));
      if ($urandom_range(0, 4) == 0) begin
         near_r = 16'($urandom);
         far_r  = 16'($urandom);
      end
      set_config(near_r, far_r, 8'($urandom), 8'($urandom),
                 16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)));
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (n_items) begin
         op = 1'($urandom_range(0, 1));
         if (op == CMD_TICK) begin
            d = 16'($urandom);
         end else begin
            case ($urandom_range(0, 9))
               0: d = '0;
               1: d = '1;
               2: d = near_r - 16'd1;
               3: d = far_r;
               4, 5: d = 16'($urandom);
               default: d = (far_r > near_r) ? 16'($urandom_range(near_r, far_r - 16'd1))
                                             : 16'($urandom);
            endcase
         end
         send_item(op, d);
      end
   endtask

   initial begin
      near_mm      = NEAR_LIMIT_RST;
      far_mm       = FAR_LIMIT_RST;
      vol_floor    = VOLUME_FLOOR_RST;
      vol_ceiling  = VOLUME_CEILING_RST;
      holdoff_ms   = START_HOLDOFF_RST;
      interval_ms  = SEND_INTERVAL_RST;
      now_ms       = '0;
      start_ms     = '0;
      last_send_ms = '0;
      playing      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_play_frame();
      test_volume_bands();
      test_floor_above_ceiling();
      test_empty_middle_band();
      test_full_scale();
      test_send_interval();

      test_random_traffic(0, 0, 39);
      test_random_traffic(62, 0, 39);
      test_random_traffic(0, 62, 39);
      test_random_traffic(37, 37, 39);
      test_random_traffic(0, 0, 39);
      test_random_traffic(62, 0, 39);
      test_random_traffic(0, 62, 39);
      test_random_traffic(37, 37, 39);

      settle();
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* files.f */
src/dvcs_pkg.sv
src/distance_to_volume_command_sender.sv
src/dvcs_checker.sv
dv/tb_top.sv
